// File: rtl/tmt_pkg.sv
// shared types, character codes and helpers for the tex markup tokenizer
package tmt_pkg;

    localparam int POS_BITS      = 32;
    localparam int DEPTH_BITS    = 8;
    localparam int FIELD_W       = 32;
    localparam int KIND_W        = 3;
    localparam int OBUF_PTR_BITS = 2;
    localparam int OBUF_DEPTH    = 1 << OBUF_PTR_BITS;
    localparam int OBUF_CNT_W    = OBUF_PTR_BITS + 1;

    typedef logic [POS_BITS-1:0]   pos_t;
    typedef logic [DEPTH_BITS-1:0] depth_t;
    typedef logic [KIND_W-1:0]     kind_t;
    typedef logic [OBUF_CNT_W-1:0] obuf_cnt_t;

    localparam pos_t   POS_MAX   = {POS_BITS{1'b1}};
    localparam depth_t DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam depth_t DEPTH_ONE = depth_t'(1);

    // buffer level at which two more results still fit
    localparam obuf_cnt_t OBUF_ROOM_LEVEL = obuf_cnt_t'(OBUF_DEPTH - 2);

    localparam kind_t KIND_TEXT    = 3'd0;
    localparam kind_t KIND_COMMAND = 3'd1;
    localparam kind_t KIND_MATH    = 3'd2;
    localparam kind_t KIND_OPEN    = 3'd3;
    localparam kind_t KIND_CLOSE   = 3'd4;
    localparam kind_t KIND_END     = 3'd5;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic [3:0] {
        MODE_IDLE      = 4'd0,
        MODE_TEXT      = 4'd1,
        MODE_DOLLAR    = 4'd2,
        MODE_BSLASH    = 4'd3,
        MODE_NAME      = 4'd4,
        MODE_OPT       = 4'd5,
        MODE_AFTER_OPT = 4'd6,
        MODE_REQ       = 4'd7,
        MODE_COMMENT   = 4'd8
    } mode_t;

    typedef struct packed {
        kind_t kind;
        pos_t  start;
        pos_t  span;
        pos_t  name_len;
        logic  has_opt;
        pos_t  opt_len;
        logic  has_req;
        pos_t  req_len;
        logic  last;
    } res_t;

    function automatic pos_t sat_inc(pos_t v);
        return (v == POS_MAX) ? v : v + pos_t'(1);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(pos_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[FIELD_W-1:0];
    endfunction

endpackage

// File: rtl/tex_markup_tokenizer_core.sv
// top level of the tex markup tokenizer: input stage, lexer and result buffer
//
//  channel | direction | handshake            | beat carries
//  --------+-----------+----------------------+--------------------------------------
//  in      | sink      | in_valid / in_stall   | src_byte, end_marker
//  out     | source    | out_valid / out_stall | token_kind .. last_result descriptor
//
// one source byte per cycle while the result buffer has room; an accepted beat is held in the
// input stage register before the lexer takes it, and its results pass through the buffer registers to out
// throughput is bounded by the four-entry result buffer: a staged byte only
// advances when two free slots remain, so a stalled out side backs up into in
// reset (rst_n low, asynchronous) returns the lexer to idle at position zero
// and empties the buffer; an end beat also returns the lexer to that state
module tex_markup_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  src_byte,
    input  logic        end_marker,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  token_kind,
    output logic [31:0] token_start,
    output logic [31:0] token_span,
    output logic [31:0] name_length,
    output logic        has_optional,
    output logic [31:0] optional_length,
    output logic        has_required,
    output logic [31:0] required_length,
    output logic        last_result
);

    // input stage
    logic               stage_valid_reg, stage_valid_next;
    logic [7:0]         stage_byte_reg;
    logic               stage_end_reg;

    logic               accept;
    logic               advance;
    logic               pop;

    tmt_pkg::res_t      res0;
    tmt_pkg::res_t      res1;
    logic [1:0]         res_n;
    logic [1:0]         push_n;
    tmt_pkg::res_t      head;
    tmt_pkg::obuf_cnt_t fifo_count;

    // lexer only steps when the buffer can absorb a double result
    assign advance  = stage_valid_reg && (fifo_count <= tmt_pkg::OBUF_ROOM_LEVEL);
    assign in_stall = stage_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;
    assign push_n   = advance ? res_n : 2'd0;

    assign stage_valid_next = accept || (stage_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    // payload of the staged beat, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= src_byte;
            stage_end_reg  <= end_marker;
        end
    end

    tmt_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .src_byte   (stage_byte_reg),
        .end_marker (stage_end_reg),
        .res0       (res0),
        .res1       (res1),
        .res_n      (res_n)
    );

    tmt_out_fifo u_out_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (push_n),
        .push0  (res0),
        .push1  (res1),
        .pop    (pop),
        .head   (head),
        .count  (fifo_count)
    );

    // result beat straight from the buffer head
    assign out_valid       = (fifo_count != '0);
    assign token_kind      = head.kind;
    assign token_start     = tmt_pkg::to_field(head.start);
    assign token_span      = tmt_pkg::to_field(head.span);
    assign name_length     = tmt_pkg::to_field(head.name_len);
    assign has_optional    = head.has_opt;
    assign optional_length = tmt_pkg::to_field(head.opt_len);
    assign has_required    = head.has_req;
    assign required_length = tmt_pkg::to_field(head.req_len);
    assign last_result     = head.last;

    // buffer never overfills
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= tmt_pkg::obuf_cnt_t'(tmt_pkg::OBUF_DEPTH))
        else $error("result buffer overfilled");

    // a new beat lands on a full stage only when the staged one moves on
    a_stage_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stage_valid_reg) |-> advance)
        else $error("staged beat overwritten");

    // an end beat always yields results, the last one flagged
    a_end_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (stage_end_reg || (stage_byte_reg == tmt_pkg::CH_NUL))) |->
        ((res_n == 2'd1 && res0.last) || (res_n == 2'd2 && res1.last && !res0.last)))
        else $error("end beat without flagged result");

    // buffer level tracks pushes and pops exactly
    a_fifo_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fifo_count == $past(fifo_count) + tmt_pkg::obuf_cnt_t'($past(push_n))
                                - tmt_pkg::obuf_cnt_t'($past(pop))))
        else $error("result buffer level mismatch");

endmodule

// File: rtl/tmt_lexer.sv
// lexer state machine: one byte per step, up to two token descriptors
module tmt_lexer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        src_byte,
    input  logic              end_marker,
    output tmt_pkg::res_t     res0,
    output tmt_pkg::res_t     res1,
    output logic [1:0]        res_n
);

    tmt_pkg::mode_t  mode_reg,   mode_next;
    tmt_pkg::pos_t   pos_reg,    pos_next;
    tmt_pkg::pos_t   pstart_reg, pstart_next;
    tmt_pkg::pos_t   nlen_reg,   nlen_next;
    tmt_pkg::depth_t depth_reg,  depth_next;
    logic            hopt_reg,   hopt_next;
    tmt_pkg::pos_t   olen_reg,   olen_next;
    tmt_pkg::pos_t   rlen_reg,   rlen_next;

    logic            is_end;
    tmt_pkg::pos_t   p_inc;
    logic            flush_has;
    tmt_pkg::res_t   flush_res;
    logic            idle_has;
    tmt_pkg::res_t   idle_res;
    tmt_pkg::mode_t  idle_mode;
    tmt_pkg::res_t   end_res;
    tmt_pkg::res_t   cmd_close_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= tmt_pkg::MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            nlen_reg   <= '0;
            depth_reg  <= '0;
            hopt_reg   <= 1'b0;
            olen_reg   <= '0;
            rlen_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            nlen_reg   <= nlen_next;
            depth_reg  <= depth_next;
            hopt_reg   <= hopt_next;
            olen_reg   <= olen_next;
            rlen_reg   <= rlen_next;
        end
    end

    assign is_end = end_marker || (src_byte == tmt_pkg::CH_NUL);
    assign p_inc  = tmt_pkg::sat_inc(pos_reg);

    // token still open, closed just before the current byte
    always_comb
    begin
        flush_res       = '0;
        flush_res.start = pstart_reg;
        flush_res.span  = pos_reg - pstart_reg;
        flush_has       = 1'b1;
        unique case (mode_reg)
            tmt_pkg::MODE_TEXT:   flush_res.kind = tmt_pkg::KIND_TEXT;
            tmt_pkg::MODE_DOLLAR: flush_res.kind = tmt_pkg::KIND_MATH;
            tmt_pkg::MODE_BSLASH, tmt_pkg::MODE_NAME, tmt_pkg::MODE_OPT,
            tmt_pkg::MODE_AFTER_OPT, tmt_pkg::MODE_REQ:
            begin
                flush_res.kind     = tmt_pkg::KIND_COMMAND;
                flush_res.name_len = nlen_reg;
                flush_res.has_opt  = hopt_reg;
                flush_res.opt_len  = olen_reg;
                flush_res.has_req  = (mode_reg == tmt_pkg::MODE_REQ);
                flush_res.req_len  = rlen_reg;
            end
            default:              flush_has = 1'b0;
        endcase
    end

    // byte seen between tokens
    always_comb
    begin
        idle_res       = '0;
        idle_res.start = pos_reg;
        idle_res.span  = p_inc - pos_reg;
        idle_has       = 1'b0;
        idle_mode      = tmt_pkg::MODE_IDLE;
        priority if (tmt_pkg::is_space(src_byte))
            idle_mode = tmt_pkg::MODE_IDLE;
        else if (src_byte == tmt_pkg::CH_DOLLAR)
            idle_mode = tmt_pkg::MODE_DOLLAR;
        else if (src_byte == tmt_pkg::CH_BSLASH)
            idle_mode = tmt_pkg::MODE_BSLASH;
        else if (src_byte == tmt_pkg::CH_LBRACE)
        begin
            idle_has      = 1'b1;
            idle_res.kind = tmt_pkg::KIND_OPEN;
        end
        else if (src_byte == tmt_pkg::CH_RBRACE)
        begin
            idle_has      = 1'b1;
            idle_res.kind = tmt_pkg::KIND_CLOSE;
        end
        else if (src_byte == tmt_pkg::CH_PERCENT)
            idle_mode = tmt_pkg::MODE_COMMENT;
        else
            idle_mode = tmt_pkg::MODE_TEXT;
    end

    always_comb
    begin
        end_res       = '0;
        end_res.kind  = tmt_pkg::KIND_END;
        end_res.start = pos_reg;
    end

    always_comb
    begin
        cmd_close_res          = flush_res;
        cmd_close_res.kind     = tmt_pkg::KIND_COMMAND;
        cmd_close_res.span     = p_inc - pstart_reg;
        cmd_close_res.has_req  = 1'b1;
    end

    always_comb
    begin
        logic          first_has;
        logic          second_has;
        logic          act_flush_idle;
        logic          act_idle;
        tmt_pkg::res_t first;
        tmt_pkg::res_t second;

        first_has      = 1'b0;
        second_has     = 1'b0;
        first          = '0;
        second         = '0;
        act_flush_idle = 1'b0;
        act_idle       = 1'b0;

        mode_next   = mode_reg;
        pos_next    = p_inc;
        pstart_next = pstart_reg;
        nlen_next   = nlen_reg;
        depth_next  = depth_reg;
        hopt_next   = hopt_reg;
        olen_next   = olen_reg;
        rlen_next   = rlen_reg;

        if (is_end)
        begin
            first_has   = flush_has;
            first       = flush_res;
            second_has  = 1'b1;
            second      = end_res;
            mode_next   = tmt_pkg::MODE_IDLE;
            pos_next    = '0;
            pstart_next = '0;
            nlen_next   = '0;
            depth_next  = '0;
            hopt_next   = 1'b0;
            olen_next   = '0;
            rlen_next   = '0;
        end
        else
        begin
            unique case (mode_reg)
                tmt_pkg::MODE_COMMENT:
                begin
                    if (src_byte == tmt_pkg::CH_NL)
                        mode_next = tmt_pkg::MODE_IDLE;
                end
                tmt_pkg::MODE_TEXT:
                begin
                    if ((src_byte == tmt_pkg::CH_BSLASH) || (src_byte == tmt_pkg::CH_LBRACE) ||
                        (src_byte == tmt_pkg::CH_RBRACE) || (src_byte == tmt_pkg::CH_PERCENT))
                        act_flush_idle = 1'b1;
                end
                tmt_pkg::MODE_DOLLAR:
                begin
                    if (src_byte == tmt_pkg::CH_DOLLAR)
                    begin
                        first_has  = 1'b1;
                        first      = flush_res;
                        first.span = p_inc - pstart_reg;
                        mode_next  = tmt_pkg::MODE_IDLE;
                    end
                    else
                        act_flush_idle = 1'b1;
                end
                tmt_pkg::MODE_BSLASH:
                begin
                    if (tmt_pkg::is_letter(src_byte))
                    begin
                        mode_next = tmt_pkg::MODE_NAME;
                        nlen_next = tmt_pkg::pos_t'(1);
                    end
                    else
                        act_flush_idle = 1'b1;
                end
                tmt_pkg::MODE_NAME:
                begin
                    priority if (tmt_pkg::is_letter(src_byte))
                        nlen_next = tmt_pkg::sat_inc(nlen_reg);
                    else if (src_byte == tmt_pkg::CH_LBRACK)
                    begin
                        mode_next  = tmt_pkg::MODE_OPT;
                        depth_next = tmt_pkg::DEPTH_ONE;
                        hopt_next  = 1'b1;
                    end
                    else if (src_byte == tmt_pkg::CH_LBRACE)
                    begin
                        mode_next  = tmt_pkg::MODE_REQ;
                        depth_next = tmt_pkg::DEPTH_ONE;
                    end
                    else
                        act_flush_idle = 1'b1;
                end
                tmt_pkg::MODE_OPT:
                begin
                    if ((src_byte == tmt_pkg::CH_RBRACK) && (depth_reg <= tmt_pkg::DEPTH_ONE))
                    begin
                        mode_next  = tmt_pkg::MODE_AFTER_OPT;
                        depth_next = '0;
                    end
                    else
                    begin
                        if (src_byte == tmt_pkg::CH_RBRACK)
                            depth_next = depth_reg - tmt_pkg::DEPTH_ONE;
                        else if ((src_byte == tmt_pkg::CH_LBRACK) &&
                                 (depth_reg != tmt_pkg::DEPTH_MAX))
                            depth_next = depth_reg + tmt_pkg::DEPTH_ONE;
                        olen_next = tmt_pkg::sat_inc(olen_reg);
                    end
                end
                tmt_pkg::MODE_AFTER_OPT:
                begin
                    if (src_byte == tmt_pkg::CH_LBRACE)
                    begin
                        mode_next  = tmt_pkg::MODE_REQ;
                        depth_next = tmt_pkg::DEPTH_ONE;
                    end
                    else
                        act_flush_idle = 1'b1;
                end
                tmt_pkg::MODE_REQ:
                begin
                    if ((src_byte == tmt_pkg::CH_RBRACE) && (depth_reg <= tmt_pkg::DEPTH_ONE))
                    begin
                        first_has  = 1'b1;
                        first      = cmd_close_res;
                        mode_next  = tmt_pkg::MODE_IDLE;
                        nlen_next  = '0;
                        depth_next = '0;
                        hopt_next  = 1'b0;
                        olen_next  = '0;
                        rlen_next  = '0;
                    end
                    else
                    begin
                        if (src_byte == tmt_pkg::CH_RBRACE)
                            depth_next = depth_reg - tmt_pkg::DEPTH_ONE;
                        else if ((src_byte == tmt_pkg::CH_LBRACE) &&
                                 (depth_reg != tmt_pkg::DEPTH_MAX))
                            depth_next = depth_reg + tmt_pkg::DEPTH_ONE;
                        rlen_next = tmt_pkg::sat_inc(rlen_reg);
                    end
                end
                default:
                    act_idle = 1'b1;
            endcase

            if (act_flush_idle || act_idle)
            begin
                mode_next  = idle_mode;
                first_has  = act_flush_idle && flush_has;
                first      = flush_res;
                second_has = idle_has;
                second     = idle_res;
                if (act_flush_idle || !tmt_pkg::is_space(src_byte))
                begin
                    nlen_next  = '0;
                    depth_next = '0;
                    hopt_next  = 1'b0;
                    olen_next  = '0;
                    rlen_next  = '0;
                end
                if (!tmt_pkg::is_space(src_byte))
                    pstart_next = pos_reg;
            end
        end

        // pack into slots, first result ahead of second
        res0      = first_has ? first : second;
        res1      = second;
        res_n     = {1'b0, first_has} + {1'b0, second_has};
        res0.last = (res_n == 2'd1);
        res1.last = 1'b1;
    end

endmodule

// File: rtl/tmt_out_fifo.sv
// four-entry result buffer taking up to two beats per cycle
module tmt_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_n,
    input  tmt_pkg::res_t       push0,
    input  tmt_pkg::res_t       push1,
    input  logic                pop,
    output tmt_pkg::res_t       head,
    output tmt_pkg::obuf_cnt_t  count
);

    tmt_pkg::res_t                       mem_reg [tmt_pkg::OBUF_DEPTH];
    logic [tmt_pkg::OBUF_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tmt_pkg::OBUF_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    tmt_pkg::obuf_cnt_t                  count_reg,  count_next;
    logic [tmt_pkg::OBUF_PTR_BITS-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_n == 2'd2)
            mem_reg[wr_ptr_plus1] <= push1;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + tmt_pkg::OBUF_PTR_BITS'(push_n);
        rd_ptr_next = rd_ptr_reg + tmt_pkg::OBUF_PTR_BITS'(pop);
        count_next  = count_reg + tmt_pkg::obuf_cnt_t'(push_n)
                                - tmt_pkg::obuf_cnt_t'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: sim/tex_markup_tokenizer_core_tb.sv
// self-checking testbench for the tex markup tokenizer core
module tex_markup_tokenizer_core_tb;

    localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no beat on either side
    localparam int unsigned ITEM_BEATS   = 650;   // minimum input beats over the whole run
    localparam int unsigned TAIL_CYCLES  = 8;

    // token predictor and store of expected descriptors
    class token_scoreboard;
        tmt_pkg::res_t   expected_tokens[$];
        int unsigned     errors;
        tmt_pkg::mode_t  mode;
        tmt_pkg::pos_t   pos;
        tmt_pkg::pos_t   tok_start;
        tmt_pkg::pos_t   name_len;
        tmt_pkg::pos_t   opt_len;
        tmt_pkg::pos_t   req_len;
        tmt_pkg::depth_t depth;
        logic            has_opt;

        function new();
            errors = 0;
            restart();
        endfunction

        function int unsigned pending();
            return expected_tokens.size();
        endfunction

        function tmt_pkg::pos_t bump(tmt_pkg::pos_t v);
            return (v == tmt_pkg::POS_MAX) ? v : v + tmt_pkg::pos_t'(1);
        endfunction

        function bit blank_char(logic [7:0] c);
            return c == tmt_pkg::CH_SPACE || c == tmt_pkg::CH_TAB || c == tmt_pkg::CH_NL ||
                   c == tmt_pkg::CH_VT || c == tmt_pkg::CH_FF || c == tmt_pkg::CH_CR;
        endfunction

        function bit alpha_char(logic [7:0] c);
            return (c >= tmt_pkg::CH_UPPER_A && c <= tmt_pkg::CH_UPPER_Z) ||
                   (c >= tmt_pkg::CH_LOWER_A && c <= tmt_pkg::CH_LOWER_Z);
        endfunction

        function void clear_args();
            name_len = '0;
            depth    = '0;
            has_opt  = 1'b0;
            opt_len  = '0;
            req_len  = '0;
        endfunction

        function void restart();
            mode      = tmt_pkg::MODE_IDLE;
            pos       = '0;
            tok_start = '0;
            clear_args();
        endfunction

        function void emit(tmt_pkg::kind_t kind, tmt_pkg::pos_t start, tmt_pkg::pos_t span,
                           tmt_pkg::pos_t nlen, logic hopt, tmt_pkg::pos_t olen, logic hreq,
                           tmt_pkg::pos_t rlen);
            tmt_pkg::res_t r;
            r.kind     = kind;
            r.start    = start;
            r.span     = span;
            r.name_len = nlen;
            r.has_opt  = hopt;
            r.opt_len  = olen;
            r.has_req  = hreq;
            r.req_len  = rlen;
            r.last     = 1'b0;
            expected_tokens.push_back(r);
        endfunction

        function void emit_command(tmt_pkg::pos_t end_pos, logic hreq);
            emit(tmt_pkg::KIND_COMMAND, tok_start, end_pos - tok_start, name_len, has_opt,
                 opt_len, hreq, req_len);
        endfunction

        // token waiting for its end, which lies just before p
        function void close_pending(tmt_pkg::pos_t p);
            case (mode)
                tmt_pkg::MODE_TEXT:
                    emit(tmt_pkg::KIND_TEXT, tok_start, p - tok_start, '0, 1'b0, '0, 1'b0, '0);
                tmt_pkg::MODE_DOLLAR:
                    emit(tmt_pkg::KIND_MATH, tok_start, p - tok_start, '0, 1'b0, '0, 1'b0, '0);
                tmt_pkg::MODE_BSLASH, tmt_pkg::MODE_NAME, tmt_pkg::MODE_OPT,
                tmt_pkg::MODE_AFTER_OPT, tmt_pkg::MODE_REQ:
                    emit_command(p, mode == tmt_pkg::MODE_REQ);
                default: ;
            endcase
            mode = tmt_pkg::MODE_IDLE;
            clear_args();
        endfunction

        // byte between tokens
        function void begin_token(logic [7:0] c, tmt_pkg::pos_t p);
            mode = tmt_pkg::MODE_IDLE;
            if (!blank_char(c))
            begin
                clear_args();
                tok_start = p;
                if (c == tmt_pkg::CH_DOLLAR)
                    mode = tmt_pkg::MODE_DOLLAR;
                else if (c == tmt_pkg::CH_BSLASH)
                    mode = tmt_pkg::MODE_BSLASH;
                else if (c == tmt_pkg::CH_LBRACE)
                    emit(tmt_pkg::KIND_OPEN, p, bump(p) - p, '0, 1'b0, '0, 1'b0, '0);
                else if (c == tmt_pkg::CH_RBRACE)
                    emit(tmt_pkg::KIND_CLOSE, p, bump(p) - p, '0, 1'b0, '0, 1'b0, '0);
                else if (c == tmt_pkg::CH_PERCENT)
                    mode = tmt_pkg::MODE_COMMENT;
                else
                    mode = tmt_pkg::MODE_TEXT;
            end
        endfunction

        // accepted input beat: work out the descriptors it causes
        function void note_beat(logic [7:0] c, logic endm);
            tmt_pkg::pos_t p;
            int            base;
            tmt_pkg::res_t r;
            p    = pos;
            base = expected_tokens.size();
            if (endm || c == tmt_pkg::CH_NUL)
            begin
                close_pending(p);
                emit(tmt_pkg::KIND_END, p, '0, '0, 1'b0, '0, 1'b0, '0);
                restart();
            end
            else
            begin
                case (mode)
                    tmt_pkg::MODE_COMMENT:
                        if (c == tmt_pkg::CH_NL)
                            mode = tmt_pkg::MODE_IDLE;
                    tmt_pkg::MODE_TEXT:
                        if (c == tmt_pkg::CH_BSLASH || c == tmt_pkg::CH_LBRACE ||
                            c == tmt_pkg::CH_RBRACE || c == tmt_pkg::CH_PERCENT)
                        begin
                            close_pending(p);
                            begin_token(c, p);
                        end
                    tmt_pkg::MODE_DOLLAR:
                        if (c == tmt_pkg::CH_DOLLAR)
                        begin
                            emit(tmt_pkg::KIND_MATH, tok_start, bump(p) - tok_start, '0,
                                 1'b0, '0, 1'b0, '0);
                            mode = tmt_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            close_pending(p);
                            begin_token(c, p);
                        end
                    tmt_pkg::MODE_BSLASH:
                        if (alpha_char(c))
                        begin
                            mode     = tmt_pkg::MODE_NAME;
                            name_len = tmt_pkg::pos_t'(1);
                        end
                        else
                        begin
                            close_pending(p);
                            begin_token(c, p);
                        end
                    tmt_pkg::MODE_NAME:
                        if (alpha_char(c))
                            name_len = bump(name_len);
                        else if (c == tmt_pkg::CH_LBRACK)
                        begin
                            mode    = tmt_pkg::MODE_OPT;
                            depth   = tmt_pkg::DEPTH_ONE;
                            has_opt = 1'b1;
                        end
                        else if (c == tmt_pkg::CH_LBRACE)
                        begin
                            mode  = tmt_pkg::MODE_REQ;
                            depth = tmt_pkg::DEPTH_ONE;
                        end
                        else
                        begin
                            close_pending(p);
                            begin_token(c, p);
                        end
                    tmt_pkg::MODE_OPT:
                        if (c == tmt_pkg::CH_RBRACK && depth <= tmt_pkg::DEPTH_ONE)
                        begin
                            mode  = tmt_pkg::MODE_AFTER_OPT;
                            depth = '0;
                        end
                        else
                        begin
                            if (c == tmt_pkg::CH_RBRACK)
                                depth = depth - tmt_pkg::DEPTH_ONE;
                            else if (c == tmt_pkg::CH_LBRACK && depth < tmt_pkg::DEPTH_MAX)
                                depth = depth + tmt_pkg::DEPTH_ONE;
                            opt_len = bump(opt_len);
                        end
                    tmt_pkg::MODE_AFTER_OPT:
                        if (c == tmt_pkg::CH_LBRACE)
                        begin
                            mode  = tmt_pkg::MODE_REQ;
                            depth = tmt_pkg::DEPTH_ONE;
                        end
                        else
                        begin
                            close_pending(p);
                            begin_token(c, p);
                        end
                    tmt_pkg::MODE_REQ:
                        if (c == tmt_pkg::CH_RBRACE && depth <= tmt_pkg::DEPTH_ONE)
                        begin
                            emit_command(bump(p), 1'b1);
                            mode = tmt_pkg::MODE_IDLE;
                            clear_args();
                        end
                        else
                        begin
                            if (c == tmt_pkg::CH_RBRACE)
                                depth = depth - tmt_pkg::DEPTH_ONE;
                            else if (c == tmt_pkg::CH_LBRACE && depth < tmt_pkg::DEPTH_MAX)
                                depth = depth + tmt_pkg::DEPTH_ONE;
                            req_len = bump(req_len);
                        end
                    default:
                        begin_token(c, p);
                endcase
                pos = bump(p);
            end
            // flag the final descriptor of this beat
            if (expected_tokens.size() > base)
            begin
                r      = expected_tokens[expected_tokens.size() - 1];
                r.last = 1'b1;
                expected_tokens[expected_tokens.size() - 1] = r;
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // accepted output beat against the oldest expectation
        function void check_token(tmt_pkg::res_t got);
            tmt_pkg::res_t want;
            if (expected_tokens.size() == 0)
            begin
                $error("token_kind: expected no descriptor, got %0d", got.kind);
                errors++;
                return;
            end
            want = expected_tokens.pop_front();
            check_field("token_kind", 32'(want.kind), 32'(got.kind));
            check_field("token_start", want.start, got.start);
            check_field("token_span", want.span, got.span);
            check_field("name_length", want.name_len, got.name_len);
            check_field("has_optional", 32'(want.has_opt), 32'(got.has_opt));
            check_field("optional_length", want.opt_len, got.opt_len);
            check_field("has_required", 32'(want.has_req), 32'(got.has_req));
            check_field("required_length", want.req_len, got.req_len);
            check_field("last_result", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  src_byte   = 8'h00;
    logic        end_marker = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [2:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_span;
    logic [31:0] name_length;
    logic        has_optional;
    logic [31:0] optional_length;
    logic        has_required;
    logic [31:0] required_length;
    logic        last_result;

    token_scoreboard sb = new();

    bit          idle_on    = 1'b1;
    bit          stall_on   = 1'b1;
    int unsigned stall_hold = 0;
    int unsigned beats_sent = 0;
    logic [7:0]  doc_q[$];

    tex_markup_tokenizer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .src_byte        (src_byte),
        .end_marker      (end_marker),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .token_kind      (token_kind),
        .token_start     (token_start),
        .token_span      (token_span),
        .name_length     (name_length),
        .has_optional    (has_optional),
        .optional_length (optional_length),
        .has_required    (has_required),
        .required_length (required_length),
        .last_result     (last_result)
    );

    always #1 clk = ~clk;

    // mostly short runs, a few long ones
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // receiver back-pressure, switched off for quiet stretches
    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            out_stall  <= stall_on && ($urandom_range(0, 2) == 0);
            stall_hold <= pick_len() - 1;
        end
    end

    // both channels sampled before the edge updates anything
    always @(posedge clk)
    begin
        tmt_pkg::res_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_beat(src_byte, end_marker);
            if (out_valid && !out_stall)
            begin
                got.kind     = token_kind;
                got.start    = token_start;
                got.span     = token_span;
                got.name_len = name_length;
                got.has_opt  = has_optional;
                got.opt_len  = optional_length;
                got.has_req  = has_required;
                got.req_len  = required_length;
                got.last     = last_result;
                sb.check_token(got);
            end
        end
    end

    // watchdog: too long without a beat on either side
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tex_markup_tokenizer_core_tb: done, errors");
        $finish;
    end

    // one input beat; payload holds while stalled, valid drops only for a real gap
    task automatic send_beat(logic [7:0] b, logic e);
        int unsigned gap;
        src_byte   <= b;
        end_marker <= e;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_len() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic ship_doc(logic [7:0] tail_byte, logic tail_end);
        foreach (doc_q[i])
            send_beat(doc_q[i], 1'b0);
        send_beat(tail_byte, tail_end);
        doc_q.delete();
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 5))
            0:       return tmt_pkg::CH_UPPER_A;
            1:       return tmt_pkg::CH_UPPER_Z;
            2:       return tmt_pkg::CH_LOWER_A;
            3:       return tmt_pkg::CH_LOWER_Z;
            4:       return 8'($urandom_range(tmt_pkg::CH_UPPER_A, tmt_pkg::CH_UPPER_Z));
            default: return 8'($urandom_range(tmt_pkg::CH_LOWER_A, tmt_pkg::CH_LOWER_Z));
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return tmt_pkg::CH_SPACE;
            1:       return tmt_pkg::CH_TAB;
            2:       return tmt_pkg::CH_NL;
            3:       return tmt_pkg::CH_VT;
            4:       return tmt_pkg::CH_FF;
            default: return tmt_pkg::CH_CR;
        endcase
    endfunction

    // any non-zero byte other than the two given
    function automatic logic [7:0] pick_filler(logic [7:0] a, logic [7:0] b);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == a || c == b);
        return c;
    endfunction

    function automatic void add_text();
        logic [7:0] c;
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 4) == 0)
                c = 8'($urandom_range(8'h80, 8'hFF));
            else
                do
                    c = 8'($urandom_range(8'h20, 8'h7E));
                while (c == tmt_pkg::CH_BSLASH || c == tmt_pkg::CH_LBRACE ||
                       c == tmt_pkg::CH_RBRACE || c == tmt_pkg::CH_PERCENT);
            doc_q.push_back(c);
        end
    endfunction

    // bracketed argument with random nesting; open_ended leaves it unclosed
    function automatic void add_arg(logic [7:0] op, logic [7:0] cl, bit open_ended);
        int unsigned lvl;
        int unsigned r;
        lvl = 0;
        doc_q.push_back(op);
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6))
        begin
            r = $urandom_range(0, 99);
            if (r < 15 && lvl < 3)
            begin
                doc_q.push_back(op);
                lvl++;
            end
            else if (r < 30 && lvl > 0)
            begin
                doc_q.push_back(cl);
                lvl--;
            end
            else
                doc_q.push_back(pick_filler(op, cl));
        end
        if (!open_ended)
            repeat (lvl + 1) doc_q.push_back(cl);
    endfunction

    function automatic void add_command(bit open_ended);
        bit with_opt;
        bit with_req;
        doc_q.push_back(tmt_pkg::CH_BSLASH);
        if ($urandom_range(0, 6) != 0)
            repeat (($urandom_range(0, 19) == 0) ? 12 : $urandom_range(1, 6))
                doc_q.push_back(pick_letter());
        with_opt = $urandom_range(0, 2) == 0;
        with_req = $urandom_range(0, 1) == 0;
        if (with_opt)
            add_arg(tmt_pkg::CH_LBRACK, tmt_pkg::CH_RBRACK, open_ended && !with_req);
        if (with_req || (open_ended && !with_opt))
            add_arg(tmt_pkg::CH_LBRACE, tmt_pkg::CH_RBRACE, open_ended);
    endfunction

    function automatic void add_comment();
        doc_q.push_back(tmt_pkg::CH_PERCENT);
        repeat ($urandom_range(0, 5))
            doc_q.push_back(pick_filler(tmt_pkg::CH_NL, tmt_pkg::CH_NL));
        if ($urandom_range(0, 9) != 0)
            doc_q.push_back(tmt_pkg::CH_NL);
    endfunction

    // nesting past the depth ceiling in an optional argument, then a short brace
    function automatic void add_deep_command();
        doc_q.push_back(tmt_pkg::CH_BSLASH);
        doc_q.push_back(tmt_pkg::CH_LOWER_A);
        doc_q.push_back(tmt_pkg::CH_LBRACK);
        repeat (256) doc_q.push_back(tmt_pkg::CH_LBRACK);
        repeat (255) doc_q.push_back(tmt_pkg::CH_RBRACK);
        doc_q.push_back(tmt_pkg::CH_LBRACE);
        doc_q.push_back(tmt_pkg::CH_LOWER_Z);
        doc_q.push_back(tmt_pkg::CH_RBRACE);
    endfunction

    // a document of mostly well-formed fragments with some noise
    function automatic void build_doc();
        int unsigned frags;
        frags = $urandom_range(0, 8);
        for (int unsigned f = 0; f < frags; f++)
        begin
            case ($urandom_range(0, 11))
                0, 1:    add_text();
                2:       repeat ($urandom_range(1, 3)) doc_q.push_back(pick_blank());
                3, 4, 5: add_command(1'b0);
                6:
                begin
                    doc_q.push_back(tmt_pkg::CH_DOLLAR);
                    if ($urandom_range(0, 1) == 0)
                        doc_q.push_back(tmt_pkg::CH_DOLLAR);
                end
                7:
                    doc_q.push_back(($urandom_range(0, 1) == 0) ? tmt_pkg::CH_LBRACE
                                                                : tmt_pkg::CH_RBRACE);
                8:       add_comment();
                9:
                begin
                    // backslash followed by any non-zero byte but A and a
                    doc_q.push_back(tmt_pkg::CH_BSLASH);
                    doc_q.push_back(pick_filler(tmt_pkg::CH_UPPER_A, tmt_pkg::CH_LOWER_A));
                end
                default:
                    repeat ($urandom_range(1, 4))
                        doc_q.push_back(pick_filler(tmt_pkg::CH_NUL, tmt_pkg::CH_NUL));
            endcase
        end
        // argument still open when the document ends
        if ($urandom_range(0, 9) == 0)
            add_command(1'b1);
    endfunction

    initial
    begin
        int unsigned docs;
        int unsigned r;
        docs = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: comment, $$ and $, text, lone backslash, option then brace,
        // all-bits byte, byte zero as end
        send_text("%c\n$$x\\{\\ab[}{]}$}\t");
        send_beat(8'hFF, 1'b0);
        send_beat(tmt_pkg::CH_NUL, 1'b0);
        // required argument left open, comment byte counted inside it
        send_text("\\Z{%");
        send_beat(8'hFF, 1'b1);
        // empty document
        send_beat(tmt_pkg::CH_NUL, 1'b1);
        in_valid <= 1'b0;
        wait_drained();

        add_deep_command();
        ship_doc(8'h00, 1'b1);

        while (beats_sent < ITEM_BEATS)
        begin
            // quiet stretches with no idling on either side
            r = $urandom_range(0, 4);
            idle_on  <= (r != 0);
            stall_on <= (r != 0);
            build_doc();
            r = $urandom_range(0, 9);
            if (r < 7)
                ship_doc(8'($urandom_range(0, 255)), 1'b1);
            else if (r < 9)
                ship_doc(tmt_pkg::CH_NUL, 1'b0);
            else
                ship_doc(tmt_pkg::CH_NUL, 1'b1);
            docs++;
            if (docs % 12 == 0)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tex_markup_tokenizer_core_tb: done, clean");
        else
            $display("tex_markup_tokenizer_core_tb: done, errors");
        $finish;
    end

endmodule
